@@ rtl/xor_checked_packet_deframer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the packet deframer
// Shared forms for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_PACKET_DEFRAMER_ASSERT_SVH
`define XOR_CHECKED_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define XCPD_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xcpd assertion failed");

// next-cycle implication
`define XCPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xcpd assertion failed");

`endif

@@ rtl/xcpd_pkg.sv @@
// ----------------------------------------------------------------------------
// xcpd_pkg
// Types and constants shared by the packet deframer modules.
// ----------------------------------------------------------------------------
package xcpd_pkg;

  localparam int MAX_PAYLOAD  = 32;
  localparam int BYTE_W       = 8;
  localparam int POS_W        = $clog2(MAX_PAYLOAD);
  localparam int LEN_W        = POS_W + 1;
  localparam int ADDR_W       = POS_W + 1;
  localparam int MEM_DEPTH    = 2 * MAX_PAYLOAD;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = QPTR_W + 1;
  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CHK
  } phase_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SHOW
  } back_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] command;
    logic [LEN_W-1:0]  length;
    logic              bank;
  } frame_desc_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } buf_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } buf_rd_t;

endpackage

@@ rtl/xcpd_buf.sv @@
// ----------------------------------------------------------------------------
// xcpd_buf
// Two-bank payload buffer, one write port, one registered read port.
// ----------------------------------------------------------------------------
module xcpd_buf (
  input  logic                          clk,
  input  xcpd_pkg::buf_wr_t             wr,
  input  xcpd_pkg::buf_rd_t             rd,
  output logic [xcpd_pkg::BYTE_W-1:0]   rd_data
);

  logic [xcpd_pkg::BYTE_W-1:0] mem [xcpd_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

@@ rtl/xcpd_front.sv @@
// ----------------------------------------------------------------------------
// xcpd_front
// Frame parser: hunts for the header, checks the XOR sum, stores payload.
// ----------------------------------------------------------------------------
module xcpd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [xcpd_pkg::BYTE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [xcpd_pkg::BYTE_W-1:0]   rx_byte,
  input  logic                          q_full,
  output logic                          push,
  output xcpd_pkg::frame_desc_t         desc,
  output xcpd_pkg::buf_wr_t             wr
);

  xcpd_pkg::phase_t                 phase, phase_next;
  logic [xcpd_pkg::BYTE_W-1:0]      header_value;
  logic [xcpd_pkg::BYTE_W-1:0]      running_xor, running_xor_next;
  logic [xcpd_pkg::BYTE_W-1:0]      held_command, held_command_next;
  logic [xcpd_pkg::LEN_W-1:0]       held_length, held_length_next;
  logic [xcpd_pkg::LEN_W-1:0]       fill_count, fill_count_next;
  logic                             wbank, wbank_next;
  logic                             accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full && (phase inside {xcpd_pkg::PH_DATA, xcpd_pkg::PH_CHK});
  assign accept    = in_valid && !in_stall;
  assign desc      = '{command: held_command, length: held_length, bank: wbank};

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= xcpd_pkg::HEADER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      header_value <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= xcpd_pkg::PH_HUNT;
      running_xor  <= '0;
      held_command <= '0;
      held_length  <= '0;
      fill_count   <= '0;
      wbank        <= 1'b0;
    end else begin
      phase        <= phase_next;
      running_xor  <= running_xor_next;
      held_command <= held_command_next;
      held_length  <= held_length_next;
      fill_count   <= fill_count_next;
      wbank        <= wbank_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    running_xor_next  = running_xor;
    held_command_next = held_command;
    held_length_next  = held_length;
    fill_count_next   = fill_count;
    wbank_next        = wbank;
    push              = 1'b0;
    wr.en             = 1'b0;
    wr.addr           = {wbank, fill_count[xcpd_pkg::POS_W-1:0]};
    wr.data           = rx_byte;
    if (accept) begin
      case (phase)
        xcpd_pkg::PH_HUNT: begin
          if (rx_byte == header_value) begin
            running_xor_next = rx_byte;
            phase_next       = xcpd_pkg::PH_CMD;
          end
        end
        xcpd_pkg::PH_CMD: begin
          held_command_next = rx_byte;
          running_xor_next  = running_xor ^ rx_byte;
          phase_next        = xcpd_pkg::PH_LEN;
        end
        xcpd_pkg::PH_LEN: begin
          held_length_next = rx_byte[xcpd_pkg::LEN_W-1:0];
          if (rx_byte > xcpd_pkg::BYTE_W'(xcpd_pkg::MAX_PAYLOAD)) begin
            phase_next = xcpd_pkg::PH_HUNT;
          end else begin
            running_xor_next = running_xor ^ rx_byte;
            fill_count_next  = '0;
            phase_next       = (rx_byte == '0) ? xcpd_pkg::PH_CHK : xcpd_pkg::PH_DATA;
          end
        end
        xcpd_pkg::PH_DATA: begin
          wr.en            = 1'b1;
          fill_count_next  = fill_count + xcpd_pkg::LEN_W'(1);
          running_xor_next = running_xor ^ rx_byte;
          if (fill_count_next >= held_length) begin
            phase_next = xcpd_pkg::PH_CHK;
          end
        end
        xcpd_pkg::PH_CHK: begin
          phase_next = xcpd_pkg::PH_HUNT;
          if (running_xor == rx_byte) begin
            push       = 1'b1;
            wbank_next = ~wbank;
          end
        end
        default: begin
          phase_next = xcpd_pkg::PH_HUNT;
        end
      endcase
    end
  end

endmodule

@@ rtl/xcpd_queue.sv @@
// ----------------------------------------------------------------------------
// xcpd_queue
// Short queue of accepted frame descriptors between parser and emitter.
// ----------------------------------------------------------------------------
module xcpd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  xcpd_pkg::frame_desc_t  desc_in,
  input  logic                   pop,
  output xcpd_pkg::frame_desc_t  head,
  output logic                   empty,
  output logic                   full
);

  xcpd_pkg::frame_desc_t          entries [xcpd_pkg::QUEUE_DEPTH];
  logic [xcpd_pkg::QPTR_W-1:0]    wptr, rptr;
  logic [xcpd_pkg::QCNT_W-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == xcpd_pkg::QCNT_W'(xcpd_pkg::QUEUE_DEPTH));
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= desc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + xcpd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + xcpd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + xcpd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - xcpd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/xcpd_back.sv @@
// ----------------------------------------------------------------------------
// xcpd_back
// Frame emitter: reads a stored frame out of the buffer as a run of results.
// ----------------------------------------------------------------------------
`include "xor_checked_packet_deframer_assert.svh"

module xcpd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  xcpd_pkg::frame_desc_t         head,
  input  logic                          empty,
  output logic                          pop,
  output xcpd_pkg::buf_rd_t             rd,
  input  logic [xcpd_pkg::BYTE_W-1:0]   rd_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [xcpd_pkg::BYTE_W-1:0]   command,
  output logic [xcpd_pkg::BYTE_W-1:0]   payload_byte,
  output logic [xcpd_pkg::POS_W-1:0]    byte_position,
  output logic [xcpd_pkg::LEN_W-1:0]    frame_length,
  output logic                          has_data,
  output logic                          last
);

  xcpd_pkg::back_state_t         state, state_next;
  logic [xcpd_pkg::POS_W-1:0]    k, k_next;
  logic                          load;
  logic                          last_item;
  logic                          item_has_data;

  assign item_has_data = (head.length != '0);
  assign last_item     = !item_has_data ||
                         ((xcpd_pkg::LEN_W'(k) + xcpd_pkg::LEN_W'(1)) == head.length);
  assign load          = (state == xcpd_pkg::B_SHOW) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xcpd_pkg::B_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    pop        = 1'b0;
    rd.en      = 1'b0;
    rd.addr    = {head.bank, k};
    case (state)
      xcpd_pkg::B_IDLE: begin
        if (!empty) begin
          k_next     = '0;
          state_next = xcpd_pkg::B_READ;
        end
      end
      xcpd_pkg::B_READ: begin
        rd.en      = 1'b1;
        state_next = xcpd_pkg::B_SHOW;
      end
      xcpd_pkg::B_SHOW: begin
        if (load) begin
          if (last_item) begin
            pop        = 1'b1;
            state_next = xcpd_pkg::B_IDLE;
          end else begin
            k_next     = k + xcpd_pkg::POS_W'(1);
            state_next = xcpd_pkg::B_READ;
          end
        end
      end
      default: begin
        state_next = xcpd_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      command       <= head.command;
      payload_byte  <= item_has_data ? rd_data : '0;
      byte_position <= item_has_data ? k : '0;
      frame_length  <= head.length;
      has_data      <= item_has_data;
      last          <= last_item;
    end
  end

  `XCPD_ASSERT(busy_has_frame, clk, rst, state != xcpd_pkg::B_IDLE, !empty)
  `XCPD_ASSERT(empty_frame_shape, clk, rst, out_valid && !has_data, last && payload_byte == '0 && byte_position == '0)
  `XCPD_ASSERT_NEXT(run_continues, clk, rst, load && !last_item, state == xcpd_pkg::B_READ)

endmodule

@@ rtl/xor_checked_packet_deframer.sv @@
// Takes one received byte per cycle; input stalls only while both buffer banks hold frames.
// A good frame's first result goes via the queue, read and show states to the outputs.
// Results leave one at a time: each buffer read is shown before the next one starts.
// Synchronous reset: parser hunts, header value 0xAA, queue and output emptied.
// The payload buffer is not cleared; only entries written by the emitted frame are output.
// ----------------------------------------------------------------------------
// xor_checked_packet_deframer
// Header/length/XOR-checksum frame parser with a decoupled result emitter.
// ----------------------------------------------------------------------------
module xor_checked_packet_deframer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [xcpd_pkg::BYTE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [xcpd_pkg::BYTE_W-1:0]   rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [xcpd_pkg::BYTE_W-1:0]   command,
  output logic [xcpd_pkg::BYTE_W-1:0]   payload_byte,
  output logic [xcpd_pkg::POS_W-1:0]    byte_position,
  output logic [xcpd_pkg::LEN_W-1:0]    frame_length,
  output logic                          has_data,
  output logic                          last
);

  xcpd_pkg::frame_desc_t          desc, head;
  xcpd_pkg::buf_wr_t              wr;
  xcpd_pkg::buf_rd_t              rd;
  logic [xcpd_pkg::BYTE_W-1:0]    rd_data;
  logic                           push, pop, q_empty, q_full;

  xcpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .q_full    (q_full),
    .push      (push),
    .desc      (desc),
    .wr        (wr)
  );

  xcpd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .desc_in (desc),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  xcpd_buf u_buf (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  xcpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .rd            (rd),
    .rd_data       (rd_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .command       (command),
    .payload_byte  (payload_byte),
    .byte_position (byte_position),
    .frame_length  (frame_length),
    .has_data      (has_data),
    .last          (last)
  );

endmodule
